// File: rtl/fdt_pkg.sv
package fdt_pkg;

  // Depth of the classify queue and of the result buffer
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [23:0] MAX24 = 24'hFF_FFFF;
  localparam logic [21:0] MAX22 = 22'h3F_FFFF;

  // Structure block tokens, host byte order
  localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TOK_END        = 32'h0000_0009;

  // Config port: register index sits at paddr[2]
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic        CFG_IDX_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ROLE_TOKEN   = 3'd0,
    ROLE_NAME    = 3'd1,
    ROLE_LEN     = 3'd2,
    ROLE_OFF     = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_IGNORED = 3'd5
  } word_role_e;

  typedef enum logic [2:0] {
    KIND_BEGIN_NODE = 3'd0,
    KIND_END_NODE   = 3'd1,
    KIND_PROP       = 3'd2,
    KIND_NOP        = 3'd3,
    KIND_END        = 3'd4,
    KIND_UNKNOWN    = 3'd5
  } token_kind_e;

  typedef enum logic [2:0] {
    MODE_TOKEN  = 3'd0,
    MODE_NAME   = 3'd1,
    MODE_LEN    = 3'd2,
    MODE_OFF    = 3'd3,
    MODE_VALUE  = 3'd4,
    MODE_HALTED = 3'd5
  } parse_mode_e;

  typedef struct packed {
    logic [31:0] data_word;
    logic        restart;
  } fdt_req_t;

  typedef struct packed {
    word_role_e  word_role;
    token_kind_e token_kind;
    logic        name_done;
    logic [23:0] value_length;
    logic [23:0] string_offset;
    logic [21:0] value_index;
    logic [23:0] byte_position;
    logic [31:0] host_word;
    logic        stopped;
  } fdt_rsp_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [31:0] host;
    logic        restart;
    token_kind_e kind;
    logic        zero_byte;
    logic [23:0] sat_val;
    logic [21:0] val_words;
  } fdt_cls_t;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// File: rtl/fdt_front.sv
module fdt_front (
  input  fdt_pkg::fdt_req_t req_i,
  output fdt_pkg::fdt_cls_t cls_o
);
  import fdt_pkg::*;

  logic [31:0] host;
  logic [23:0] sat;
  logic [24:0] rnd;
  logic [22:0] words;

  assign host = swap32(req_i.data_word);
  assign sat  = (host[31:24] != 8'd0) ? MAX24 : host[23:0];
  assign rnd  = {1'b0, sat} + 25'd3;
  assign words = rnd[24:2];

  always_comb begin
    cls_o.host      = host;
    cls_o.restart   = req_i.restart;
    cls_o.sat_val   = sat;
    cls_o.val_words = words[22] ? MAX22 : words[21:0];
    cls_o.zero_byte = (host[7:0] == 8'd0) || (host[15:8] == 8'd0) ||
                      (host[23:16] == 8'd0) || (host[31:24] == 8'd0);
    unique case (host)
      TOK_BEGIN_NODE: cls_o.kind = KIND_BEGIN_NODE;
      TOK_END_NODE:   cls_o.kind = KIND_END_NODE;
      TOK_PROP:       cls_o.kind = KIND_PROP;
      TOK_NOP:        cls_o.kind = KIND_NOP;
      TOK_END:        cls_o.kind = KIND_END;
      default:        cls_o.kind = KIND_UNKNOWN;
    endcase
  end

endmodule

// File: rtl/fdt_queue.sv
module fdt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fdt_pkg::fdt_cls_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output fdt_pkg::fdt_cls_t data_o
);
  import fdt_pkg::*;

  fdt_cls_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/fdt_back.sv
module fdt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [23:0]       size_i,
  input  logic              valid_i,
  input  fdt_pkg::fdt_cls_t cls_i,
  output logic              take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output fdt_pkg::fdt_rsp_t rsp_o
);
  import fdt_pkg::*;

  parse_mode_e mode_q, mode_d, mode_eff;
  logic [23:0] pos_q, pos_d, pos_eff;
  logic [21:0] left_q, left_d, left_eff, left_dec;
  logic [23:0] len_q, len_d, len_eff;
  logic [23:0] off_q, off_d, off_eff;
  logic [21:0] vidx_q, vidx_d, vidx_eff;
  logic [24:0] pos_inc;
  logic        active;
  fdt_rsp_t    rsp;

  // Result buffer
  fdt_rsp_t          obuf_q [QDEPTH];
  logic [QPTR_W-1:0] owr_q, owr_d, ord_q, ord_d;
  logic [QCNT_W-1:0] ocnt_q, ocnt_d;
  logic              do_pop;

  assign take_o  = valid_i && (ocnt_q != QCNT_W'(QDEPTH));
  assign empty_o = (ocnt_q == '0);
  assign rsp_o   = obuf_q[ord_q];
  assign do_pop  = pop_i && !empty_o;

  // Restart clears the walk state before the word is parsed
  assign mode_eff = cls_i.restart ? MODE_TOKEN : mode_q;
  assign pos_eff  = cls_i.restart ? '0 : pos_q;
  assign left_eff = cls_i.restart ? '0 : left_q;
  assign len_eff  = cls_i.restart ? '0 : len_q;
  assign off_eff  = cls_i.restart ? '0 : off_q;
  assign vidx_eff = cls_i.restart ? '0 : vidx_q;
  assign active   = (mode_eff != MODE_HALTED) && (pos_eff < size_i);
  assign left_dec = (left_eff != '0) ? left_eff - 1'b1 : left_eff;
  assign pos_inc  = {1'b0, pos_eff} + 25'd4;

  // Next parse mode
  always_comb begin
    mode_d = mode_eff;
    if (active) begin
      unique case (mode_eff)
        MODE_TOKEN: begin
          unique case (cls_i.kind)
            KIND_BEGIN_NODE: mode_d = MODE_NAME;
            KIND_PROP:       mode_d = MODE_LEN;
            KIND_UNKNOWN:    mode_d = MODE_HALTED;
            default:         mode_d = MODE_TOKEN;
          endcase
        end
        MODE_NAME:  mode_d = cls_i.zero_byte ? MODE_TOKEN : MODE_NAME;
        MODE_LEN:   mode_d = MODE_OFF;
        MODE_OFF:   mode_d = (left_eff == '0) ? MODE_TOKEN : MODE_VALUE;
        MODE_VALUE: mode_d = (left_dec == '0) ? MODE_TOKEN : MODE_VALUE;
        default:    mode_d = mode_eff;
      endcase
    end
  end

  // Datapath state and result
  always_comb begin
    pos_d  = pos_eff;
    left_d = left_eff;
    len_d  = len_eff;
    off_d  = off_eff;
    vidx_d = vidx_eff;
    rsp.word_role  = ROLE_IGNORED;
    rsp.token_kind = KIND_BEGIN_NODE;
    rsp.name_done  = 1'b0;
    rsp.value_index = '0;
    if (active) begin
      pos_d = pos_inc[24] ? MAX24 : pos_inc[23:0];
      unique case (mode_eff)
        MODE_TOKEN: begin
          rsp.word_role  = ROLE_TOKEN;
          rsp.token_kind = cls_i.kind;
        end
        MODE_NAME: begin
          rsp.word_role = ROLE_NAME;
          rsp.name_done = cls_i.zero_byte;
        end
        MODE_LEN: begin
          rsp.word_role = ROLE_LEN;
          len_d  = cls_i.sat_val;
          left_d = cls_i.val_words;
        end
        MODE_OFF: begin
          rsp.word_role = ROLE_OFF;
          off_d  = cls_i.sat_val;
          vidx_d = '0;
        end
        MODE_VALUE: begin
          rsp.word_role   = ROLE_VALUE;
          rsp.value_index = vidx_eff;
          vidx_d = vidx_eff + 1'b1;
          left_d = left_dec;
        end
        default: rsp.word_role = ROLE_IGNORED;
      endcase
    end
    rsp.value_length  = len_d;
    rsp.string_offset = off_d;
    rsp.byte_position = pos_eff;
    rsp.host_word     = cls_i.host;
    rsp.stopped       = (mode_d == MODE_HALTED);
  end

  always_comb begin
    owr_d  = owr_q;
    ord_d  = ord_q;
    ocnt_d = ocnt_q;
    if (take_o) begin
      owr_d = (owr_q == QPTR_W'(QDEPTH - 1)) ? '0 : owr_q + 1'b1;
    end
    if (do_pop) begin
      ord_d = (ord_q == QPTR_W'(QDEPTH - 1)) ? '0 : ord_q + 1'b1;
    end
    if (take_o && !do_pop) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (!take_o && do_pop) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TOKEN;
      pos_q  <= '0;
      left_q <= '0;
      len_q  <= '0;
      off_q  <= '0;
      vidx_q <= '0;
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (take_o) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        left_q <= left_d;
        len_q  <= len_d;
        off_q  <= off_d;
        vidx_q <= vidx_d;
      end
      owr_q  <= owr_d;
      ord_q  <= ord_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      obuf_q[owr_q] <= rsp;
    end
  end

endmodule

// File: rtl/fdt_structure_token_parser.sv
// Flattened device tree structure block parser. Push one structure word per
// request as it sits in memory (big-endian); the block byte-swaps it, tracks
// its place in the block and returns one result per request: the word's role
// (token, node name, property length, name offset, value word or ignored),
// the token kind, the current property length and name offset, the value
// word index and the word's byte offset. Set restart on the first word of a
// block. An unknown token halts the parser (stopped) until a restart; words
// at or past struct_size_bytes are ignored and change nothing. Program
// struct_size_bytes at address 0 while no request is in flight. Throughput
// is one request per clock unless a queue is full: the front end decodes
// each word independently, and the back end updates its walk state once per
// accepted word. A request is written into the classify queue when it is
// accepted; the back end then takes it from the queue and writes its result
// into the result buffer, from where it can be popped. Both queues are two
// deep, so either side may stall without a bubble.
module fdt_structure_token_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request side
  input  logic                                push,
  output logic                                full,
  input  fdt_pkg::fdt_req_t                   req_i,
  // result side
  output logic                                empty,
  input  logic                                pop,
  output fdt_pkg::fdt_rsp_t                   rsp_o,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fdt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import fdt_pkg::*;

  logic [23:0] size_q;
  fdt_cls_t    cls_in, cls_head;
  logic        q_valid, q_take;

  // Config register: struct_size_bytes, low 24 bits of the write data
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_SIZE) ? {8'd0, size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_SIZE)) begin
      size_q <= pwdata[23:0];
    end
  end

  // Front end: byte swap, token decode, length saturation and zero-byte check, stateless
  fdt_front u_front (
    .req_i (req_i),
    .cls_o (cls_in)
  );

  fdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (q_take),
    .valid_o (q_valid),
    .data_o  (cls_head)
  );

  // Back end: parse state walk and result buffer
  fdt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .size_i  (size_q),
    .valid_i (q_valid),
    .cls_i   (cls_head),
    .take_o  (q_take),
    .empty_o (empty),
    .pop_i   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

// File: rtl/fdt_checker.sv
module fdt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input fdt_pkg::fdt_req_t              req_i,
  input logic                           empty,
  input logic                           pop,
  input fdt_pkg::fdt_rsp_t              rsp_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [fdt_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);
  import fdt_pkg::*;

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rsp_o))
    else $error("result changed while stalled");

  // Only an unknown token can halt a live parse
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rsp_o.stopped && (rsp_o.word_role != ROLE_IGNORED)
      |-> (rsp_o.word_role == ROLE_TOKEN) && (rsp_o.token_kind == KIND_UNKNOWN))
    else $error("halt without unknown token");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (rsp_o.word_role != ROLE_TOKEN) |-> rsp_o.token_kind == KIND_BEGIN_NODE)
    else $error("token kind on non-token word");

  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((rsp_o.word_role == ROLE_NAME) || !rsp_o.name_done) &&
               ((rsp_o.word_role == ROLE_VALUE) || (rsp_o.value_index == '0)))
    else $error("name_done or value_index on wrong role");

endmodule

bind fdt_structure_token_parser fdt_checker u_fdt_checker (.*);
